/* hdl/chained_hash_map_top_macros.svh */
// ----------------------------------------------------------------------------
// chained_hash_map_top_macros.svh
// Assertion macros shared by the hash map RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_TOP_MACROS_SVH
`define CHAINED_HASH_MAP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CHM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hash map assertion failed");
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash map implication failed");
`else
`define CHM_ASSERT(lbl, clk, rst_n, prop)
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/chm_pkg.sv */
// ----------------------------------------------------------------------------
// chm_pkg
// Transaction types, opcodes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_W     = 31;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 9;

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_GET      = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [KEY_W-1:0]        key;
    logic signed [DATA_W-1:0] data_in;
  } chm_in_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] data_out;
    logic                     status;
    logic [COUNT_W-1:0]       entry_count;
  } chm_out_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic head_rd;
    logic head_load;
    logic walk;
    logic hit_load;
    logic pop_rd;
    logic pop_load;
    logic fresh_take;
    logic put_data;
    logic link_new;
    logic link_prev;
    logic unl_hit;
    logic unl_prev;
    logic full;
    logic finish;
  } chm_cmd_t;

  typedef struct packed {
    op_t  op;
    logic found;
    logic clr_last;
    logic mod_done;
    logic head_nil;
    logic key_match;
    logic next_nil;
    logic free_nil;
    logic fresh_avail;
    logic prev_nil;
    logic out_free;
  } chm_stat_t;

endpackage

/* hdl/chm_ram.sv */
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/chm_mod.sv */
// ----------------------------------------------------------------------------
// chm_mod
// Bucket index unit: key modulo BUCKETS. Mask for powers of two, otherwise
// a two-stage reciprocal multiplication.
// ----------------------------------------------------------------------------
module chm_mod #(
  parameter int BUCKETS = 64,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [chm_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [BW-1:0]             rem
);

  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  generate
    if (BUCKETS == 1) begin : g_one
      logic done_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end
      assign done = done_r;
      assign rem  = '0;
    end else if (POW2) begin : g_mask
      logic          done_r;
      logic [BW-1:0] rem_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end
      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= key[BW-1:0];
        end
      end
      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_recip
      // q = (key * ceil(2^SH / BUCKETS)) >> SH is exact for every 31-bit key
      localparam int MW = chm_pkg::KEY_W + 1;
      localparam int PW = chm_pkg::KEY_W + MW;
      localparam int SH = chm_pkg::KEY_W + BW;
      localparam logic [63:0] M64 =
        ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
      localparam logic [MW-1:0] MUL = MW'(M64);
      localparam logic [BW-1:0] BLO = BW'(BUCKETS);

      logic          s1_r;
      logic          done_r;
      logic [BW-1:0] qlo_r;
      logic [BW-1:0] klo_r;
      logic [BW-1:0] rem_r;
      logic [PW-1:0] prod;

      assign prod = PW'(key) * PW'(MUL);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          s1_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          s1_r   <= start;
          done_r <= s1_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          qlo_r <= prod[SH +: BW];
          klo_r <= key[BW-1:0];
        end
        if (s1_r) begin
          rem_r <= klo_r - BW'(qlo_r * BLO);
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end
  endgenerate

endmodule

/* hdl/chm_ctrl.sv */
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer: bucket clear after reset, then per transaction hash, chain walk,
// update and result hand-off.
// ----------------------------------------------------------------------------
`include "chained_hash_map_top_macros.svh"

module chm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  chm_pkg::chm_stat_t   stat,
  output chm_pkg::chm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HEAD,
    ST_CMP,
    ST_RES,
    ST_POP,
    ST_LINK,
    ST_LINK_P,
    ST_UNL_P,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          cmd.head_rd = 1'b1;
          state_nxt   = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd.head_load = 1'b1;
        state_nxt     = stat.head_nil ? ST_RES : ST_CMP;
      end
      ST_CMP: begin
        if (stat.key_match) begin
          cmd.hit_load = 1'b1;
          state_nxt    = ST_RES;
        end else begin
          cmd.walk  = 1'b1;
          state_nxt = stat.next_nil ? ST_RES : ST_CMP;
        end
      end
      ST_RES: begin
        state_nxt = ST_FIN;
        unique case (stat.op) inside
          chm_pkg::OP_PUT: begin
            if (stat.found) begin
              cmd.put_data = 1'b1;
            end else if (!stat.free_nil) begin
              cmd.pop_rd = 1'b1;
              state_nxt  = ST_POP;
            end else if (stat.fresh_avail) begin
              cmd.fresh_take = 1'b1;
              state_nxt      = ST_LINK;
            end else begin
              cmd.full = 1'b1;
            end
          end
          chm_pkg::OP_REMOVE: begin
            if (stat.found) begin
              cmd.unl_hit = 1'b1;
              state_nxt   = stat.prev_nil ? ST_FIN : ST_UNL_P;
            end
          end
          chm_pkg::OP_GET, chm_pkg::OP_CONTAINS: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_LINK;
      end
      ST_LINK: begin
        cmd.link_new = 1'b1;
        state_nxt    = stat.prev_nil ? ST_FIN : ST_LINK_P;
      end
      ST_LINK_P: begin
        cmd.link_prev = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_UNL_P: begin
        cmd.unl_prev = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  `CHM_ASSERT_IMP(a_prev_write, clk, rst_n, cmd.link_prev || cmd.unl_prev, !stat.prev_nil)
  `CHM_ASSERT_IMP(a_fresh_take, clk, rst_n, cmd.fresh_take, stat.fresh_avail && stat.free_nil)
  `CHM_ASSERT(a_one_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)

endmodule

/* hdl/chm_datapath.sv */
// ----------------------------------------------------------------------------
// chm_datapath
// Bucket head and node memories, chain pointers, free list, entry count
// and output register.
// ----------------------------------------------------------------------------
`include "chained_hash_map_top_macros.svh"

module chm_datapath #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chm_pkg::chm_cmd_t   cmd,
  output chm_pkg::chm_stat_t  stat,
  input  chm_pkg::chm_in_t    in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output chm_pkg::chm_out_t   out_item
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(NODES + 1);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [NW-1:0] NIL      = NW'(NODES);
  localparam logic [BW-1:0] CLR_LAST = BW'(BUCKETS - 1);

  chm_pkg::op_t                  op_r;
  logic [chm_pkg::KEY_W-1:0]     key_r;
  logic [chm_pkg::DATA_W-1:0]    din_r;
  logic [NW-1:0]                 cur_r;
  logic [NW-1:0]                 prev_r;
  logic [NW-1:0]                 n_r;
  logic [NW-1:0]                 free_r;
  logic [NW-1:0]                 fresh_r;
  logic [NW-1:0]                 cnt_r;
  logic                          found_r;
  logic                          status_r;
  logic [BW-1:0]                 clr_cnt_r;
  logic                          out_valid_r;
  chm_pkg::chm_out_t             out_r;

  logic [BW-1:0]                 rem;
  logic                          mod_done;
  logic [NW-1:0]                 bkt_q;
  logic [chm_pkg::KEY_W-1:0]     key_q;
  logic [chm_pkg::DATA_W-1:0]    data_q;
  logic [NW-1:0]                 next_q;

  logic                          bkt_we;
  logic [BW-1:0]                 bkt_waddr;
  logic [NW-1:0]                 bkt_wdata;
  logic                          node_rd;
  logic [NW-1:0]                 rd_link;
  logic                          dat_we;
  logic [AW-1:0]                 dat_waddr;
  logic                          nxt_we;
  logic [NW-1:0]                 nxt_waddr;
  logic [NW-1:0]                 nxt_wdata;
  logic [NW-1:0]                 nxt_raddr;
  logic [chm_pkg::DATA_W-1:0]    dout;

  chm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.accept),
    .key   (in_item.key),
    .done  (mod_done),
    .rem   (rem)
  );

  always_comb begin
    node_rd = cmd.head_load | cmd.walk;
    rd_link = cmd.head_load ? bkt_q : next_q;

    bkt_we    = cmd.clr_step | ((cmd.link_new | cmd.unl_hit) & (prev_r == NIL));
    bkt_waddr = cmd.clr_step ? clr_cnt_r : rem;
    if (cmd.clr_step) begin
      bkt_wdata = NIL;
    end else if (cmd.link_new) begin
      bkt_wdata = n_r;
    end else begin
      bkt_wdata = next_q;
    end

    dat_we    = cmd.link_new | cmd.put_data;
    dat_waddr = cmd.put_data ? cur_r[AW-1:0] : n_r[AW-1:0];

    nxt_we = cmd.link_new | cmd.link_prev | cmd.unl_hit | cmd.unl_prev;
    if (cmd.link_new) begin
      nxt_waddr = n_r;
      nxt_wdata = NIL;
    end else if (cmd.link_prev) begin
      nxt_waddr = prev_r;
      nxt_wdata = n_r;
    end else if (cmd.unl_hit) begin
      nxt_waddr = cur_r;
      nxt_wdata = free_r;
    end else begin
      nxt_waddr = prev_r;
      nxt_wdata = next_q;
    end
    nxt_raddr = cmd.pop_rd ? free_r : rd_link;
  end

  chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .re    (cmd.head_rd),
    .raddr (rem),
    .rdata (bkt_q)
  );

  chm_ram #(.WIDTH(chm_pkg::KEY_W), .DEPTH(NODES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.link_new),
    .waddr (n_r[AW-1:0]),
    .wdata (key_r),
    .re    (node_rd),
    .raddr (rd_link[AW-1:0]),
    .rdata (key_q)
  );

  chm_ram #(.WIDTH(chm_pkg::DATA_W), .DEPTH(NODES)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (din_r),
    .re    (node_rd),
    .raddr (rd_link[AW-1:0]),
    .rdata (data_q)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr[AW-1:0]),
    .wdata (nxt_wdata),
    .re    (node_rd | cmd.pop_rd),
    .raddr (nxt_raddr[AW-1:0]),
    .rdata (next_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= NIL;
      fresh_r     <= '0;
      cnt_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + BW'(1);
      end
      if (cmd.fresh_take) begin
        fresh_r <= fresh_r + NW'(1);
      end
      if (cmd.pop_load) begin
        free_r <= next_q;
      end else if (cmd.unl_hit) begin
        free_r <= cur_r;
      end
      if (cmd.link_new) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (cmd.unl_hit) begin
        cnt_r <= cnt_r - NW'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign dout = (op_r == chm_pkg::OP_GET && found_r) ? data_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= chm_pkg::op_t'(in_item.opcode);
      key_r    <= in_item.key;
      din_r    <= in_item.data_in;
      found_r  <= 1'b0;
      status_r <= 1'b0;
    end
    if (cmd.head_load) begin
      cur_r  <= bkt_q;
      prev_r <= NIL;
    end else if (cmd.walk) begin
      cur_r  <= next_q;
      prev_r <= cur_r;
    end
    if (cmd.hit_load) begin
      found_r <= 1'b1;
    end
    if (cmd.full) begin
      status_r <= 1'b1;
    end
    if (cmd.pop_load) begin
      n_r <= free_r;
    end else if (cmd.fresh_take) begin
      n_r <= fresh_r;
    end
    if (cmd.finish) begin
      out_r.found       <= found_r;
      out_r.data_out    <= dout;
      out_r.status      <= status_r;
      out_r.entry_count <= chm_pkg::COUNT_W'(cnt_r);
    end
  end

  always_comb begin
    stat.op          = op_r;
    stat.found       = found_r;
    stat.clr_last    = (clr_cnt_r == CLR_LAST);
    stat.mod_done    = mod_done;
    stat.head_nil    = (bkt_q == NIL);
    stat.key_match   = (key_q == key_r);
    stat.next_nil    = (next_q == NIL);
    stat.free_nil    = (free_r == NIL);
    stat.fresh_avail = (fresh_r != NIL);
    stat.prev_nil    = (prev_r == NIL);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `CHM_ASSERT(a_count_bound, clk, rst_n, cnt_r <= NIL)
  `CHM_ASSERT_IMP(a_found_full, clk, rst_n, out_valid_r, !(out_r.found && out_r.status))
  `CHM_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop_load, free_r != NIL)

endmodule

/* hdl/chained_hash_map_top.sv */
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Key-value store with separate chaining over a pool of NODES nodes.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  input   | in_valid, in_stall, in_item  | opcode, key, data_in
//  output  | out_valid, out_stall, out_item | found, data_out, status, entry_count
//
// One transaction at a time: bucket index, bucket head read, chain walk (one node
// memory read per cycle), then any chain or free-list update before the result.
// After reset a clearing pass empties the bucket heads; in_stall stays high
// meanwhile. A stalled result holds in the output register; the next
// transaction is accepted but completes only once it leaves.
// ----------------------------------------------------------------------------
module chained_hash_map_top #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chm_pkg::chm_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output chm_pkg::chm_out_t  out_item
);

  chm_pkg::chm_cmd_t  cmd;
  chm_pkg::chm_stat_t stat;

  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  chm_datapath #(
    .BUCKETS (BUCKETS),
    .NODES   (NODES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* bench/tb_chained_hash_map_top.sv */
// ----------------------------------------------------------------------------
// tb_chained_hash_map_top
// Self-checking bench for the chained hash map: a table of directed
// transactions, then random ones over a small colliding key set, a fill past
// the node pool and a drain through the free list. Typed rows are checked
// against their table entry, the rest against an in-bench model of the map. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_chained_hash_map_top;
  timeunit 1ns;
  timeprecision 1ps;
  import chm_pkg::*;

  localparam int BUCKETS = 64;
  localparam int NODES   = 256;
  localparam int NIL     = NODES;

  typedef struct {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data;
    bit                  typed;
    chm_out_t            want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  chm_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  chm_out_t out_item;

  bit       typed_pending = 1'b0;
  chm_out_t typed_want = '0;
  bit       calm = 1'b0;
  int       errors = 0;
  chm_out_t results_due[$];

  // map model state
  int                head_of [BUCKETS];
  logic [KEY_W-1:0]  key_at [NODES];
  logic [DATA_W-1:0] val_at [NODES];
  int                link_at [NODES];
  int                free_top;
  int                fresh_next;
  int                held;

  chained_hash_map_top #(.BUCKETS(BUCKETS), .NODES(NODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic chm_out_t map_apply(chm_in_t it);
    int b;
    int prev;
    int cur;
    int hit;
    int n;
    chm_out_t r;
    b = int'(it.key % BUCKETS);
    prev = NIL;
    cur = head_of[b];
    hit = NIL;
    while (cur != NIL) begin
      if (key_at[cur] == it.key) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = link_at[cur];
    end
    r = '0;
    r.found = (hit != NIL);
    case (op_t'(it.opcode))
      OP_PUT: begin
        if (hit != NIL) begin
          val_at[hit] = it.data_in;
        end else begin
          if (free_top != NIL) begin
            n = free_top;
            free_top = link_at[n];
          end else if (fresh_next < NODES) begin
            n = fresh_next;
            fresh_next++;
          end else begin
            n = NIL;
          end
          if (n == NIL) begin
            r.status = 1'b1;
          end else begin
            key_at[n] = it.key;
            val_at[n] = it.data_in;
            link_at[n] = NIL;
            if (prev != NIL) link_at[prev] = n;
            else head_of[b] = n;
            held++;
          end
        end
      end
      OP_GET: begin
        if (hit != NIL) r.data_out = val_at[hit];
      end
      OP_REMOVE: begin
        if (hit != NIL) begin
          if (prev != NIL) link_at[prev] = link_at[hit];
          else head_of[b] = link_at[hit];
          link_at[hit] = free_top;
          free_top = hit;
          held--;
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    chm_out_t want;
    chm_out_t got;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0b data_out=%0d status=%0b entry_count=%0d",
                 $time, out_item.found, out_item.data_out, out_item.status,
                 out_item.entry_count);
      end else begin
        want = results_due.pop_front();
        if (out_item !== want) begin
          errors++;
          $display("%0t: mismatch expected found=%0b data_out=%0d status=%0b entry_count=%0d",
                   $time, want.found, want.data_out, want.status, want.entry_count);
          $display("%0t:          actual   found=%0b data_out=%0d status=%0b entry_count=%0d",
                   $time, out_item.found, out_item.data_out, out_item.status,
                   out_item.entry_count);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      got = map_apply(in_item);
      results_due.push_back(typed_pending ? typed_want : got);
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  task automatic send_txn(input chm_in_t it, input bit typed, input chm_out_t want);
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    typed_pending <= typed;
    typed_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic dir_row_t drow(op_t op, logic [KEY_W-1:0] key,
                                    logic [DATA_W-1:0] data, bit typed,
                                    logic f, logic [DATA_W-1:0] d, int c);
    dir_row_t x;
    x.op = op;
    x.key = key;
    x.data = data;
    x.typed = typed;
    x.want = '0;
    x.want.found = f;
    x.want.data_out = d;
    x.want.entry_count = COUNT_W'(c);
    return x;
  endfunction

  initial begin : stimulus
    dir_row_t          rows[$];
    chm_in_t           it;
    logic [KEY_W-1:0]  pool [32];
    logic [KEY_W-1:0]  fresh[$];
    logic [KEY_W-1:0]  kmax;
    int                fresh_puts;
    int                k;
    int                r;

    for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
    free_top = NIL;
    fresh_next = 0;
    held = 0;
    kmax = '1;

    rows.push_back(drow(OP_GET,      0,    0,            1, 0, 0,            0));
    rows.push_back(drow(OP_CONTAINS, kmax, 0,            1, 0, 0,            0));
    rows.push_back(drow(OP_REMOVE,   5,    0,            1, 0, 0,            0));
    rows.push_back(drow(OP_PUT,      0,    32'h7FFFFFFF, 1, 0, 0,            1));
    rows.push_back(drow(OP_PUT,      kmax, 32'h80000000, 1, 0, 0,            2));
    rows.push_back(drow(OP_GET,      0,    0,            1, 1, 32'h7FFFFFFF, 2));
    rows.push_back(drow(OP_GET,      kmax, 0,            1, 1, 32'h80000000, 2));
    rows.push_back(drow(OP_PUT,      64,   32'hFFFFFFFF, 1, 0, 0,            3));
    rows.push_back(drow(OP_PUT,      128,  1,            1, 0, 0,            4));
    rows.push_back(drow(OP_PUT,      64,   5,            1, 1, 0,            4));
    rows.push_back(drow(OP_GET,      64,   0,            1, 1, 5,            4));
    rows.push_back(drow(OP_CONTAINS, 128,  0,            1, 1, 0,            4));
    rows.push_back(drow(OP_REMOVE,   64,   0,            1, 1, 0,            3));
    rows.push_back(drow(OP_GET,      64,   0,            1, 0, 0,            3));
    rows.push_back(drow(OP_GET,      128,  0,            1, 1, 1,            3));
    rows.push_back(drow(OP_REMOVE,   0,    0,            1, 1, 0,            2));
    rows.push_back(drow(OP_GET,      128,  0,            1, 1, 1,            2));
    rows.push_back(drow(OP_PUT,      192,  32'h5A5A5A5A, 0, 0, 0,            0));
    rows.push_back(drow(OP_REMOVE,   256,  0,            1, 0, 0,            3));
    rows.push_back(drow(OP_GET,      256,  0,            1, 0, 0,            3));
    rows.push_back(drow(OP_CONTAINS, 0,    0,            1, 0, 0,            3));
    rows.push_back(drow(OP_PUT,      0,    0,            0, 0, 0,            0));
    rows.push_back(drow(OP_GET,      kmax, 1234,         1, 1, 32'h80000000, 4));
    rows.push_back(drow(OP_REMOVE,   kmax, 0,            1, 1, 0,            3));
    rows.push_back(drow(OP_REMOVE,   kmax, 0,            1, 0, 0,            3));

    // small key set with heavy bucket collisions; bit 30 clear
    for (int i = 0; i < 32; i++) begin
      r = $urandom_range(0, 3);
      pool[i] = {1'b0, 24'($urandom_range(0, 7)),
                 (r == 0) ? 6'd3 : (r == 1) ? 6'd17 : (r == 2) ? 6'd40 : 6'd63};
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      it.opcode = rows[i].op;
      it.key = rows[i].key;
      it.data_in = rows[i].data;
      send_txn(it, rows[i].typed, rows[i].want);
    end

    for (k = 0; k < 100; k++) begin
      it.opcode = ($urandom_range(0, 99) < 35) ? OP_PUT : op_t'($urandom_range(0, 3));
      it.key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 31)]
                                             : KEY_W'($urandom);
      it.data_in = $urandom;
      send_txn(it, 1'b0, '0);
    end

    wait_empty();

    // fill past the node pool with unique keys (bit 30 set)
    fresh_puts = 0;
    k = 0;
    while (fresh_puts < NODES + 16) begin
      calm = (k < 100);
      if (k % 5 == 4) begin
        r = $urandom_range(0, 2);
        it.opcode = (r == 0) ? OP_GET : (r == 1) ? OP_CONTAINS : OP_PUT;
        it.key = fresh[$urandom_range(0, fresh.size() - 1)];
      end else begin
        it.opcode = OP_PUT;
        it.key = {1'b1, 24'(fresh.size()), 6'($urandom_range(0, 63))};
        fresh.push_back(it.key);
        fresh_puts++;
      end
      it.data_in = $urandom;
      send_txn(it, 1'b0, '0);
      k++;
    end
    calm = 1'b0;

    wait_empty();

    for (k = 0; k < 80; k++) begin
      r = $urandom_range(0, 99);
      it.data_in = $urandom;
      if (r < 40) begin
        it.opcode = OP_REMOVE;
        it.key = fresh[$urandom_range(0, fresh.size() - 1)];
      end else if (r < 60) begin
        it.opcode = OP_PUT;
        it.key = {1'b1, 24'(fresh.size()), 6'($urandom_range(0, 63))};
        fresh.push_back(it.key);
      end else if (r < 80) begin
        it.opcode = OP_GET;
        it.key = fresh[$urandom_range(0, fresh.size() - 1)];
      end else begin
        it.opcode = op_t'($urandom_range(0, 3));
        it.key = pool[$urandom_range(0, 31)];
      end
      send_txn(it, 1'b0, '0);
    end

    wait_empty();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/chm_pkg.sv
hdl/chm_ram.sv
hdl/chm_mod.sv
hdl/chm_ctrl.sv
hdl/chm_datapath.sv
hdl/chained_hash_map_top.sv
bench/tb_chained_hash_map_top.sv
